>>> src/top_k_score_table_defines.svh
// ---------------------------------------------------------------------------
// top_k_score_table_defines: assertion macros for the score table
// ---------------------------------------------------------------------------
`ifndef TOP_K_SCORE_TABLE_DEFINES_SVH
`define TOP_K_SCORE_TABLE_DEFINES_SVH

`ifndef ASSERT_OFF

// plain property checked on every clock edge out of reset
`define TKS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// same-cycle implication
`define TKS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TKS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`else

`define TKS_ASSERT(lbl, clk, rstn, prop, msg)
`define TKS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define TKS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

>>> src/tks_pkg.sv
// ---------------------------------------------------------------------------
// tks_pkg: shared types and constants of the top-k score table
// Field widths, command codes, window limit and the stored entry layout.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tks_pkg;

  // field widths
  localparam int unsigned KeyW   = 32;
  localparam int unsigned ScoreW = 48;
  localparam int unsigned DayW   = 16;
  localparam int unsigned SecW   = 17;
  localparam int unsigned RankW  = 5;

  // table depth default and dump length limit
  localparam int unsigned RankDepthDef = 16;
  localparam int unsigned MaxResults   = 16;

  // adds at or after this second of the day are ignored
  localparam logic [SecW-1:0] WindowEnd = 17'd79200;

  // rank size after reset
  localparam logic [RankW-1:0] RankSizeRst = 5'd10;

  // command codes
  localparam logic CmdAdd  = 1'b0;
  localparam logic CmdDump = 1'b1;

  // one stored table entry
  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic [ScoreW-1:0] score;
  } entry_t;

  localparam int unsigned EntryW = KeyW + ScoreW;

endpackage

`default_nettype wire

>>> src/tks_if.sv
// ---------------------------------------------------------------------------
// tks_if: valid/ready channels of the top-k score table
// Input word (add or dump command) and result word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tks_item_if import tks_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [KeyW-1:0]   entry_key;
  logic [ScoreW-1:0] score;
  logic [DayW-1:0]   day_number;
  logic [SecW-1:0]   second_of_day;

  modport source (output valid, cmd, entry_key, score, day_number, second_of_day,
                  input ready);
  modport sink   (input valid, cmd, entry_key, score, day_number, second_of_day,
                  output ready);
endinterface

interface tks_result_if import tks_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              accepted;
  logic              entry_valid;
  logic [KeyW-1:0]   out_key;
  logic [ScoreW-1:0] out_score;
  logic              last;

  modport source (output valid, accepted, entry_valid, out_key, out_score, last,
                  input ready);
  modport sink   (input valid, accepted, entry_valid, out_key, out_score, last,
                  output ready);
endinterface

`default_nettype wire

>>> src/tks_ram.sv
// ---------------------------------------------------------------------------
// tks_ram: generic simple dual-port RAM
// One write port, one read port, registered read data held when not read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tks_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> src/top_k_score_table.sv
// ---------------------------------------------------------------------------
// top_k_score_table: descending top-k table of (key, score) entries
// Adds merge a new entry into the ranked table, dumps stream the table.
// ---------------------------------------------------------------------------
//
//   channel    dir  handshake       word
//   item_i     in   valid/ready     cmd, entry_key, score, day_number,
//                                   second_of_day
//   result_o   out  valid/ready     accepted, entry_valid, out_key,
//                                   out_score, last
//   cfg        in   cfg_we_i        cfg_wdata_i = table size
//
// Ignored adds and empty dumps go straight to the result; a full-table add
// checks the lowest entry first, and a rejected add stops there; a taken
// add merges old entries and the new one into the other bank; a dump reads
// and loads each streamed entry. item_i is ready only in idle; a waiting
// result on result_o stalls the sequencer only when the next result is due.
// Reset clears count and day; the count bounds every read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "top_k_score_table_defines.svh"

module top_k_score_table import tks_pkg::*; #(
  parameter int unsigned RANK_DEPTH = RankDepthDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [RankW-1:0] cfg_wdata_i,
  tks_item_if.sink              item_i,
  tks_result_if.source          result_o
);

  localparam int unsigned IdxW    = $clog2(RANK_DEPTH);
  localparam int unsigned CntW    = $clog2(RANK_DEPTH + 1);
  localparam int unsigned CmpW    = (CntW > RankW) ? CntW : RankW;
  localparam int unsigned RamDepth = 2 * (2 ** IdxW);
  localparam int unsigned RamAw   = IdxW + 1;

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_ADD_LAST = 9'b000000010,
    ST_ADD_CHK  = 9'b000000100,
    ST_MRG_RD   = 9'b000001000,
    ST_MRG_WR   = 9'b000010000,
    ST_MRG_TAIL = 9'b000100000,
    ST_RESULT   = 9'b001000000,
    ST_DMP_RD   = 9'b010000000,
    ST_DMP_LD   = 9'b100000000
  } state_e;

  state_e            state_q, state_d;
  logic [RankW-1:0]  rank_q;
  logic [DayW-1:0]   day_q, day_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              bank_q, bank_d;
  logic [CntW-1:0]   rd_idx_q, rd_idx_d;
  logic [CntW-1:0]   wr_idx_q, wr_idx_d;
  logic [CntW-1:0]   dmp_n_q, dmp_n_d;
  logic              removed_q, removed_d;
  logic              inserted_q, inserted_d;
  logic              res_acc_q, res_acc_d;
  logic [KeyW-1:0]   key_q, key_d;
  logic [ScoreW-1:0] score_q, score_d;

  // output register
  logic              out_valid_q;
  logic              out_acc_q, out_vld_q, out_last_q;
  logic [KeyW-1:0]   out_key_q;
  logic [ScoreW-1:0] out_score_q;
  logic              out_load;
  logic              ld_acc, ld_vld, ld_last;
  logic [KeyW-1:0]   ld_key;
  logic [ScoreW-1:0] ld_score;
  logic              slot_free;

  // ram port signals
  logic              ram_we, ram_re;
  logic [RamAw-1:0]  ram_waddr, ram_raddr;
  logic [EntryW-1:0] ram_rdata;
  entry_t            new_entry, rd_entry, wr_entry;

  // effective rank size and item decode
  logic [CmpW-1:0]   rank_ext, eff_ext, cnt_ext, dmp_ext;
  logic [CntW-1:0]   eff;
  logic [CntW-1:0]   cnt_new;
  logic [CntW-1:0]   last_idx;
  logic              in_acc;

  assign in_acc    = item_i.valid && item_i.ready;
  assign item_i.ready = (state_q == ST_IDLE);
  assign slot_free = !out_valid_q || result_o.ready;
  assign new_entry = '{key: key_q, score: score_q};
  assign rd_entry  = entry_t'(ram_rdata);
  assign last_idx  = count_q - CntW'(1);
  assign cnt_new   = (item_i.day_number != day_q) ? '0 : count_q;

  // clamp rank size to 1..RANK_DEPTH
  always_comb begin
    rank_ext = (rank_q == '0) ? CmpW'(1) : CmpW'(rank_q);
    eff_ext  = (rank_ext > CmpW'(RANK_DEPTH)) ? CmpW'(RANK_DEPTH) : rank_ext;
    eff      = CntW'(eff_ext);
    cnt_ext  = CmpW'(cnt_new);
    dmp_ext  = (cnt_ext > CmpW'(MaxResults)) ? CmpW'(MaxResults) : cnt_ext;
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    day_d      = day_q;
    count_d    = count_q;
    bank_d     = bank_q;
    rd_idx_d   = rd_idx_q;
    wr_idx_d   = wr_idx_q;
    dmp_n_d    = dmp_n_q;
    removed_d  = removed_q;
    inserted_d = inserted_q;
    res_acc_d  = res_acc_q;
    key_d      = key_q;
    score_d    = score_q;
    ram_re     = 1'b0;
    ram_raddr  = {bank_q, rd_idx_q[IdxW-1:0]};
    ram_we     = 1'b0;
    ram_waddr  = {~bank_q, wr_idx_q[IdxW-1:0]};
    wr_entry   = new_entry;
    out_load   = 1'b0;
    ld_acc     = res_acc_q;
    ld_vld     = 1'b0;
    ld_key     = '0;
    ld_score   = '0;
    ld_last    = 1'b1;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          day_d      = item_i.day_number;
          count_d    = cnt_new;
          key_d      = item_i.entry_key;
          score_d    = item_i.score;
          rd_idx_d   = '0;
          wr_idx_d   = '0;
          removed_d  = 1'b0;
          inserted_d = 1'b0;
          dmp_n_d    = CntW'(dmp_ext);
          if (item_i.cmd == CmdAdd) begin
            if (item_i.second_of_day >= WindowEnd) begin
              res_acc_d = 1'b1;
              state_d   = ST_RESULT;
            end else begin
              state_d = ST_ADD_LAST;
            end
          end else if (dmp_ext == '0) begin
            res_acc_d = 1'b0;
            state_d   = ST_RESULT;
          end else begin
            state_d = ST_DMP_RD;
          end
        end
      end

      // fetch the lowest entry when the table is full
      ST_ADD_LAST: begin
        if ((count_q >= eff) && (count_q != '0)) begin
          ram_re    = 1'b1;
          ram_raddr = {bank_q, last_idx[IdxW-1:0]};
          state_d   = ST_ADD_CHK;
        end else begin
          state_d = ST_MRG_RD;
        end
      end

      ST_ADD_CHK: begin
        if (rd_entry.score > score_q) begin
          res_acc_d = 1'b0;
          state_d   = ST_RESULT;
        end else begin
          state_d = ST_MRG_RD;
        end
      end

      // read the next old entry, or finish once all are read or the table is full
      ST_MRG_RD: begin
        if ((rd_idx_q == count_q) || (wr_idx_q >= eff)) begin
          state_d = ST_MRG_TAIL;
        end else begin
          ram_re   = 1'b1;
          rd_idx_d = rd_idx_q + CntW'(1);
          state_d  = ST_MRG_WR;
        end
      end

      // drop the old copy of the key, place the new entry, copy the rest
      ST_MRG_WR: begin
        if (wr_idx_q >= eff) begin
          state_d = ST_MRG_RD;
        end else if (!removed_q && (rd_entry.key == key_q)) begin
          removed_d = 1'b1;
          state_d   = ST_MRG_RD;
        end else if (!inserted_q && (score_q > rd_entry.score)) begin
          ram_we     = 1'b1;
          wr_idx_d   = wr_idx_q + CntW'(1);
          inserted_d = 1'b1;
        end else begin
          ram_we   = 1'b1;
          wr_entry = rd_entry;
          wr_idx_d = wr_idx_q + CntW'(1);
          state_d  = ST_MRG_RD;
        end
      end

      // new entry goes last if it still fits, then flip banks
      ST_MRG_TAIL: begin
        if (!inserted_q && (wr_idx_q < eff)) begin
          ram_we  = 1'b1;
          count_d = wr_idx_q + CntW'(1);
        end else begin
          count_d = wr_idx_q;
        end
        bank_d    = ~bank_q;
        res_acc_d = 1'b1;
        state_d   = ST_RESULT;
      end

      ST_RESULT: begin
        if (slot_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      ST_DMP_RD: begin
        ram_re   = 1'b1;
        rd_idx_d = rd_idx_q + CntW'(1);
        state_d  = ST_DMP_LD;
      end

      ST_DMP_LD: begin
        ld_acc   = 1'b0;
        ld_vld   = 1'b1;
        ld_key   = rd_entry.key;
        ld_score = rd_entry.score;
        ld_last  = (rd_idx_q == dmp_n_q);
        if (slot_free) begin
          out_load = 1'b1;
          state_d  = ld_last ? ST_IDLE : ST_DMP_RD;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rank_q     <= RankSizeRst;
      day_q      <= '0;
      count_q    <= '0;
      bank_q     <= 1'b0;
      rd_idx_q   <= '0;
      wr_idx_q   <= '0;
      dmp_n_q    <= '0;
      removed_q  <= 1'b0;
      inserted_q <= 1'b0;
      res_acc_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      day_q      <= day_d;
      count_q    <= count_d;
      bank_q     <= bank_d;
      rd_idx_q   <= rd_idx_d;
      wr_idx_q   <= wr_idx_d;
      dmp_n_q    <= dmp_n_d;
      removed_q  <= removed_d;
      inserted_q <= inserted_d;
      res_acc_q  <= res_acc_d;
      if (cfg_we_i) begin
        rank_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    score_q <= score_d;
    if (out_load) begin
      out_acc_q   <= ld_acc;
      out_vld_q   <= ld_vld;
      out_key_q   <= ld_key;
      out_score_q <= ld_score;
      out_last_q  <= ld_last;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.accepted    = out_acc_q;
  assign result_o.entry_valid = out_vld_q;
  assign result_o.out_key     = out_key_q;
  assign result_o.out_score   = out_score_q;
  assign result_o.last        = out_last_q;

  // two-bank entry store, written with the new entry or a copied old one
  tks_ram #(
    .Width (EntryW),
    .Depth (RamDepth)
  ) u_table_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_entry),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  `TKS_ASSERT(a_count_le_depth, clk_i, rst_ni,
    count_q <= CntW'(RANK_DEPTH), "entry count above table depth")
  `TKS_ASSERT_IMP(a_no_result_overwrite, clk_i, rst_ni, out_load && out_valid_q,
    result_o.ready, "result register overwritten while waiting")
  `TKS_ASSERT_IMP(a_write_below_rank, clk_i, rst_ni, ram_we,
    wr_idx_q < eff, "table write beyond rank size")
  `TKS_ASSERT_NEXT(a_trimmed_after_merge, clk_i, rst_ni, state_q == ST_MRG_TAIL,
    count_q <= $past(eff), "table not trimmed after merge")

endmodule

`default_nettype wire

>>> tb/sv/tb_top_k_score_table.sv
// ---------------------------------------------------------------------------
// tb_top_k_score_table: self-checking bench for the top-k score table
// Drives add and dump words with random gaps, stalls the result channel at
// random, and checks every result word against an in-bench predictor or a
// literal. A short directed table leads, then random phases at several sizes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top_k_score_table import tks_pkg::*; ();

  localparam int unsigned SecondsPerDay = 86400;
  localparam int unsigned DrainCycles   = 48;
  localparam int unsigned QuietLimit    = 4000;
  localparam int unsigned IdleMax       = 17;
  localparam int unsigned PhaseCount    = 10;
  localparam int unsigned PhaseItems    = 26;
  localparam int unsigned DirRows       = 25;
  localparam int unsigned KeyPool       = 24;

  typedef enum logic [1:0] {ROW_ADD, ROW_DUMP, ROW_CFG} row_kind_e;
  // how a directed row is checked: by the predictor or by a literal result
  typedef enum logic [1:0] {CHK_MODEL, CHK_TAKEN, CHK_REJECT, CHK_EMPTY} row_chk_e;

  typedef struct packed {
    logic              cmd;
    logic [KeyW-1:0]   key;
    logic [ScoreW-1:0] score;
    logic [DayW-1:0]   day;
    logic [SecW-1:0]   sec;
  } score_item_t;

  typedef struct packed {
    logic              accepted;
    logic              entry_valid;
    logic [KeyW-1:0]   key;
    logic [ScoreW-1:0] score;
    logic              last;
  } score_result_t;

  typedef struct packed {
    row_kind_e         kind;
    logic [KeyW-1:0]   key;
    logic [ScoreW-1:0] score;
    logic [DayW-1:0]   day;
    logic [SecW-1:0]   sec;
    logic [RankW-1:0]  rank;
    row_chk_e          chk;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [RankW-1:0] cfg_wdata;

  tks_item_if   item_bus ();
  tks_result_if result_bus ();

  top_k_score_table dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .item_i     (item_bus),
    .result_o   (result_bus)
  );

  // predicted table state
  logic [KeyW-1:0]   table_key   [RankDepthDef];
  logic [ScoreW-1:0] table_score [RankDepthDef];
  int unsigned       table_count = 0;
  logic [DayW-1:0]   table_day   = '0;
  logic [RankW-1:0]  rank_cfg    = RankSizeRst;

  score_result_t expected_words [$];
  score_result_t step_words [$];
  int unsigned   error_count = 0;
  int unsigned   send_max = IdleMax;
  int unsigned   take_max = IdleMax;
  logic [DayW-1:0] drive_day = '0;
  logic [KeyW-1:0] key_base  = '0;

  // directed rows: extremes, window edge, day change, full table cases
  dir_row_t dir_rows [DirRows] = '{
    '{ROW_DUMP, 32'h0,         48'h0,              16'h0000, 17'd0,     5'd0,  CHK_EMPTY},
    '{ROW_ADD,  32'h1,         48'hFFFF_FFFF_FFFF, 16'h0000, 17'd0,     5'd0,  CHK_TAKEN},
    '{ROW_ADD,  32'hFFFF_FFFF, 48'h0,              16'h0000, 17'd79199, 5'd0,  CHK_TAKEN},
    '{ROW_ADD,  32'h2,         48'd100,            16'h0000, 17'd79200, 5'd0,  CHK_TAKEN},
    '{ROW_ADD,  32'h3,         48'd5,              16'h0000, 17'd86399, 5'd0,  CHK_TAKEN},
    '{ROW_DUMP, 32'h0,         48'h0,              16'h0000, 17'd0,     5'd0,  CHK_MODEL},
    '{ROW_ADD,  32'h1,         48'd50,             16'h0000, 17'd10,    5'd0,  CHK_TAKEN},
    '{ROW_ADD,  32'h4,         48'd50,             16'h0000, 17'd20,    5'd0,  CHK_TAKEN},
    '{ROW_DUMP, 32'h0,         48'h0,              16'h0000, 17'd30,    5'd0,  CHK_MODEL},
    '{ROW_DUMP, 32'h0,         48'h0,              16'hFFFF, 17'd30,    5'd0,  CHK_EMPTY},
    '{ROW_CFG,  32'h0,         48'h0,              16'h0000, 17'd0,     5'd2,  CHK_MODEL},
    '{ROW_ADD,  32'd10,        48'd300,            16'hFFFF, 17'd100,   5'd0,  CHK_TAKEN},
    '{ROW_ADD,  32'd11,        48'd200,            16'hFFFF, 17'd101,   5'd0,  CHK_TAKEN},
    '{ROW_ADD,  32'd12,        48'd199,            16'hFFFF, 17'd102,   5'd0,  CHK_REJECT},
    '{ROW_ADD,  32'd13,        48'd200,            16'hFFFF, 17'd103,   5'd0,  CHK_TAKEN},
    '{ROW_DUMP, 32'h0,         48'h0,              16'hFFFF, 17'd104,   5'd0,  CHK_MODEL},
    '{ROW_ADD,  32'd11,        48'd150,            16'hFFFF, 17'd105,   5'd0,  CHK_REJECT},
    '{ROW_ADD,  32'd11,        48'd200,            16'hFFFF, 17'd106,   5'd0,  CHK_TAKEN},
    '{ROW_ADD,  32'd11,        48'd400,            16'hFFFF, 17'd107,   5'd0,  CHK_TAKEN},
    '{ROW_DUMP, 32'h0,         48'h0,              16'hFFFF, 17'd108,   5'd0,  CHK_MODEL},
    '{ROW_CFG,  32'h0,         48'h0,              16'h0000, 17'd0,     5'd0,  CHK_MODEL},
    '{ROW_DUMP, 32'h0,         48'h0,              16'hFFFF, 17'd109,   5'd0,  CHK_MODEL},
    '{ROW_ADD,  32'd20,        48'd0,              16'hFFFF, 17'd1,     5'd0,  CHK_REJECT},
    '{ROW_ADD,  32'd21,        48'd500,            16'hFFFF, 17'd65536, 5'd0,  CHK_TAKEN},
    '{ROW_DUMP, 32'h0,         48'h0,              16'hFFFF, 17'd110,   5'd0,  CHK_MODEL}
  };

  int unsigned phase_rank [PhaseCount] = '{31, 16, 1, 4, 0, 16, 3, 2, 10, 31};

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // table predictor: works out the result words of one accepted item
  function automatic void predict_table(score_item_t it);
    logic [KeyW-1:0]   merged_key   [RankDepthDef+1];
    logic [ScoreW-1:0] merged_score [RankDepthDef+1];
    int unsigned   eff;
    int unsigned   n;
    int unsigned   pos;
    bit            removed;
    score_result_t r;
    step_words.delete();
    if (it.day != table_day) begin
      table_day   = it.day;
      table_count = 0;
    end
    r      = '0;
    r.last = 1'b1;
    if (it.cmd == CmdAdd) begin
      r.accepted = 1'b1;
      if (it.sec < WindowEnd) begin
        eff = (rank_cfg == 0) ? 1 : ((rank_cfg > RankDepthDef) ? RankDepthDef : rank_cfg);
        if (table_count >= eff && table_count > 0 &&
            table_score[table_count-1] > it.score) begin
          r.accepted = 1'b0;
        end else begin
          // drop the first entry of the same key
          n       = 0;
          removed = 1'b0;
          for (int unsigned i = 0; i < table_count; i++) begin
            if (!removed && table_key[i] == it.key) begin
              removed = 1'b1;
            end else begin
              merged_key[n]   = table_key[i];
              merged_score[n] = table_score[i];
              n++;
            end
          end
          // new entry goes after all equal or higher scores
          pos = 0;
          while (pos < n && it.score <= merged_score[pos]) pos++;
          for (int unsigned i = n; i > pos; i--) begin
            merged_key[i]   = merged_key[i-1];
            merged_score[i] = merged_score[i-1];
          end
          merged_key[pos]   = it.key;
          merged_score[pos] = it.score;
          n++;
          if (n > eff) n = eff;
          for (int unsigned i = 0; i < n; i++) begin
            table_key[i]   = merged_key[i];
            table_score[i] = merged_score[i];
          end
          table_count = n;
        end
      end
      step_words = {step_words, r};
    end else if (table_count == 0) begin
      step_words = {step_words, r};
    end else begin
      for (int unsigned i = 0; i < table_count && i < MaxResults; i++) begin
        r.entry_valid = 1'b1;
        r.key         = table_key[i];
        r.score       = table_score[i];
        r.last        = (i + 1 == table_count || i + 1 == MaxResults);
        step_words = {step_words, r};
      end
    end
  endfunction

  // random add or dump: mostly adds in the window on the current day
  function automatic score_item_t random_item();
    score_item_t it;
    logic [63:0] wide;
    it.cmd = ($urandom_range(0, 99) < 15) ? CmdDump : CmdAdd;
    if ($urandom_range(0, 39) == 0) begin
      wide      = {$urandom, $urandom};
      drive_day = wide[DayW-1:0];
    end
    it.day = drive_day;
    if ($urandom_range(0, 11) == 0)
      it.sec = SecW'($urandom_range(WindowEnd, SecondsPerDay - 1));
    else
      it.sec = SecW'($urandom_range(0, WindowEnd - 1));
    if ($urandom_range(0, 9) == 0)
      it.key = $urandom;
    else
      it.key = key_base + KeyW'($urandom_range(0, KeyPool - 1));
    wide = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: it.score = ScoreW'($urandom_range(0, 15));
      1: it.score = wide[ScoreW-1:0];
      2: it.score = {ScoreW{1'b1}} - ScoreW'($urandom_range(0, 7));
      default: it.score = ScoreW'(1000 + $urandom_range(0, 63));
    endcase
    return it;
  endfunction

  // present one word after a random gap, predict on acceptance
  task automatic send_item(score_item_t it, row_chk_e chk);
    int unsigned   gap;
    score_result_t lit;
    gap = $urandom_range(0, send_max);
    if (gap != 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_bus.valid         <= 1'b1;
    item_bus.cmd           <= it.cmd;
    item_bus.entry_key     <= it.key;
    item_bus.score         <= it.score;
    item_bus.day_number    <= it.day;
    item_bus.second_of_day <= it.sec;
    do @(posedge clk); while (!item_bus.ready);
    predict_table(it);
    lit      = '0;
    lit.last = 1'b1;
    case (chk)
      CHK_TAKEN:  lit.accepted = 1'b1;
      CHK_REJECT: lit.accepted = 1'b0;
      default:    ;
    endcase
    if (chk == CHK_MODEL)
      foreach (step_words[i]) expected_words = {expected_words, step_words[i]};
    else
      expected_words = {expected_words, lit};
  endtask

  // rank size write once the table has gone quiet
  task automatic write_rank(logic [RankW-1:0] value);
    item_bus.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    rank_cfg = value;
  endtask

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // stimulus: directed rows, then random phases
  initial begin
    score_item_t it;
    rst_n                  <= 1'b0;
    cfg_we                 <= 1'b0;
    cfg_wdata              <= '0;
    item_bus.valid         <= 1'b0;
    item_bus.cmd           <= CmdAdd;
    item_bus.entry_key     <= '0;
    item_bus.score         <= '0;
    item_bus.day_number    <= '0;
    item_bus.second_of_day <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_rank(dir_rows[i].rank);
      end else begin
        it.cmd   = (dir_rows[i].kind == ROW_DUMP) ? CmdDump : CmdAdd;
        it.key   = dir_rows[i].key;
        it.score = dir_rows[i].score;
        it.day   = dir_rows[i].day;
        it.sec   = dir_rows[i].sec;
        send_item(it, dir_rows[i].chk);
      end
    end

    drive_day = 16'hFFFF;
    for (int unsigned ph = 0; ph < PhaseCount; ph++) begin
      if (ph == 6 || ph == 9)
        write_rank(RankW'($urandom_range(0, 31)));
      else
        write_rank(RankW'(phase_rank[ph]));
      // some phases run back to back on one side or both
      send_max = ($urandom_range(0, 2) == 0) ? 0 : IdleMax;
      take_max = ($urandom_range(0, 2) == 0) ? 0 : IdleMax;
      key_base = $urandom;
      repeat (PhaseItems) send_item(random_item(), CHK_MODEL);
    end

    // drain and report
    item_bus.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0)
      $display("tb_top_k_score_table passed");
    else
      $display("tb_top_k_score_table failed");
    $finish;
  end

  // result side: random stalls, check each word against the oldest expectation
  initial begin
    int unsigned   stall;
    score_result_t got;
    score_result_t want;
    result_bus.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = $urandom_range(0, take_max);
      if (stall != 0) begin
        result_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_bus.ready <= 1'b1;
      do @(posedge clk); while (!result_bus.valid);
      got.accepted    = result_bus.accepted;
      got.entry_valid = result_bus.entry_valid;
      got.key         = result_bus.out_key;
      got.score       = result_bus.out_score;
      got.last        = result_bus.last;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %0h", $time, got);
        error_count++;
      end else begin
        want = expected_words.pop_front();
        check_field("accepted", 64'(want.accepted), 64'(got.accepted));
        check_field("entry_valid", 64'(want.entry_valid), 64'(got.entry_valid));
        check_field("out_key", 64'(want.key), 64'(got.key));
        check_field("out_score", 64'(want.score), 64'(got.score));
        check_field("last", 64'(want.last), 64'(got.last));
      end
    end
  end

  // watchdog on cycles with no handshake on either channel
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles == QuietLimit) begin
        $display("%0t: no handshake for %0d cycles", $time, QuietLimit);
        $display("tb_top_k_score_table failed");
        $finish;
      end
    end
  end

endmodule
